@@ src/lzbd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzbd_pkg: shared types and constants for the bit-packed LZ77 decoder
// Token phase codes, field width limits and register indexes.
// ----------------------------------------------------------------------------
package lzbd_pkg;

   localparam int HistDepthDefault = 4096;

   localparam int OffMax = 12;
   localparam int LenMax = 5;
   localparam int CntMax = 8;

   typedef enum logic [1:0] {
      PH_LEN = 2'd0,
      PH_OFF = 2'd1,
      PH_CNT = 2'd2,
      PH_LIT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_BITS = 2'd0,
      ST_COPY = 2'd1,
      ST_HALT = 2'd2
   } state_type;

   localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [1:0] REG_LENGTH_BITS = 2'd1;
   localparam logic [1:0] REG_COUNT_BITS  = 2'd2;

   // result payload: {bad_offset, stream_end, last_of_run, out_byte}
   typedef struct packed {
      logic       bad_offset;
      logic       stream_end;
      logic       last_of_run;
      logic [7:0] out_byte;
   } rsp_type;

   function automatic logic [3:0] clamp_width(input logic [3:0] v, input logic [3:0] hi);
      logic [3:0] r;
      begin
         r = v;
         if (v == 4'd0) r = 4'd1;
         else if (v > hi) r = hi;
         return r;
      end
   endfunction

endpackage

@@ src/lzbd_hist.sv @@
// ----------------------------------------------------------------------------
// lzbd_hist: history memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzbd_hist #(
   parameter int HIST_DEPTH = lzbd_pkg::HistDepthDefault,
   localparam int AW = $clog2(HIST_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [HIST_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ src/lz77_bit_packed_decoder.sv @@
// ----------------------------------------------------------------------------
// lz77_bit_packed_decoder: bit-packed LZ77 stream decoder
// Parses length/offset/count tokens from a byte stream, MSB first, and emits
// decoded bytes from literals or from a history memory.
// ----------------------------------------------------------------------------
// channel | dir | tdata                | tuser / tlast
// req     | in  | in_byte[7:0]         | -
// rsp     | out | out_byte[7:0]        | tuser {bad_offset, stream_end}, tlast last_of_run
// csr     | in  | index 0..2, data 4b  | -
//
// Each input byte is first accepted, then its bits are parsed in turn.
// Each copied byte of a match is a memory read, then a write and emit.
// Each result waits in a hold register until its last_of_run flag is known,
// then moves to the output register; parsing and copying stall while the
// hold register is full and the output register is full and not taken.
// Reset is synchronous; the history memory is not cleared (offsets are
// checked against the count of written bytes). After an end or error
// transaction the block drops every input byte until reset.
// ----------------------------------------------------------------------------
module lz77_bit_packed_decoder #(
   parameter int HIST_DEPTH = lzbd_pkg::HistDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] stream_end, [1] bad_offset
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import lzbd_pkg::*;

   localparam int AW = $clog2(HIST_DEPTH);
   localparam int CW = $clog2(HIST_DEPTH + 1);
   localparam logic [CW-1:0] DepthC = CW'(HIST_DEPTH);

   logic [3:0] off_bits_ff, cnt_bits_ff;
   logic [2:0] len_bits_ff;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  seen_ff, seen_in;
   logic [5:0]  mlen_ff, mlen_in;
   logic [7:0]  lits_ff, lits_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] nw_ff, nw_in;
   logic [11:0] dist_ff, dist_in;
   logic [7:0]  byte_ff, byte_in;   // input byte being parsed
   logic [2:0]  bit_ff, bit_in;     // bit index, 7 down to 0
   logic        rd_pend_ff, rd_pend_in; // read data valid next cycle

   // busy_byte_ff: an input byte is held and still has bits to parse
   logic busy_byte_ff, busy_byte_in;

   // hold register: newest result, waits until last_of_run is decided
   logic    hv_ff, hv_in;
   logic    hfin_ff, hfin_in;
   rsp_type hd_ff, hd_in;

   // output register
   logic    ov_ff, ov_in;
   rsp_type od_ff, od_in;

   // result produced this cycle
   logic    new_res;
   rsp_type new_rsp;
   logic    fin;        // the current input byte is done with results

   // memory ports
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   lzbd_hist #(.HIST_DEPTH(HIST_DEPTH)) u_hist (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         off_bits_ff <= 4'd12;
         len_bits_ff <= 3'd4;
         cnt_bits_ff <= 4'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OFFSET_BITS: off_bits_ff <= csr_wdata;
            REG_LENGTH_BITS: len_bits_ff <= csr_wdata[2:0];
            REG_COUNT_BITS:  cnt_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic out_free, hold_free;
   assign out_free   = !ov_ff || rsp_tready;
   assign hold_free  = !hv_ff || out_free;
   assign req_tready = (state_ff == ST_BITS && !busy_byte_ff) || state_ff == ST_HALT;

   // history source address of the next copy byte (wraps)
   logic [AW-1:0] src_addr;
   logic [AW:0]   src_sum;
   logic [AW:0]   dist_x;
   always_comb begin
      dist_x   = (AW+1)'(dist_ff);
      src_sum  = {1'b0, wp_ff} - dist_x;
      src_addr = src_sum[AW] ? AW'(src_sum + (AW+1)'(HIST_DEPTH)) : src_sum[AW-1:0];
   end

   logic [3:0] width;
   logic       bitv;
   logic [11:0] acc_n;
   logic [3:0]  seen_n;
   logic        last_bit;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; acc_in = acc_ff; seen_in = seen_ff;
      mlen_in = mlen_ff; lits_in = lits_ff; wp_in = wp_ff; nw_in = nw_ff;
      dist_in = dist_ff; byte_in = byte_ff; bit_in = bit_ff; rd_pend_in = 1'b0;
      busy_byte_in = busy_byte_ff;
      ov_in = ov_ff && !rsp_tready; od_in = od_ff;
      hv_in = hv_ff; hd_in = hd_ff; hfin_in = hfin_ff;
      new_res = 1'b0; new_rsp = '0; fin = 1'b0;
      wr_en = 1'b0; wr_addr = wp_ff; wr_data = rd_data; rd_addr = src_addr;

      unique case (phase_ff)
         PH_LEN:  width = clamp_width({1'b0, len_bits_ff}, 4'(LenMax));
         PH_OFF:  width = clamp_width(off_bits_ff, 4'(OffMax));
         PH_CNT:  width = clamp_width(cnt_bits_ff, 4'(CntMax));
         default: width = 4'd8;
      endcase
      bitv     = byte_ff[bit_ff];
      acc_n    = {acc_ff[10:0], bitv};
      seen_n   = seen_ff + 4'd1;
      last_bit = (bit_ff == 3'd0);

      unique case (state_ff)
         ST_BITS: begin
            if (!busy_byte_ff) begin
               if (req_tvalid) begin
                  byte_in = req_tdata; busy_byte_in = 1'b1; bit_in = 3'd7;
               end
            end else if (hold_free) begin
               // one bit per cycle while the hold slot is free; every bit waits for it
               acc_in = acc_n; seen_in = seen_n;
               bit_in = bit_ff - 3'd1;
               fin = last_bit;
               if (last_bit) busy_byte_in = 1'b0;
               if (seen_n >= width) begin
                  acc_in = '0; seen_in = '0;
                  unique case (phase_ff)
                     PH_LEN: phase_in = (acc_n != '0) ? PH_OFF : PH_CNT;
                     PH_OFF: begin
                        if (acc_n == '0 || CW'(acc_n) > nw_ff ||
                            (CW < 12 && acc_n[11:0] > 12'(nw_ff))) begin
                           new_res = 1'b1; new_rsp = '{1'b1, 1'b0, 1'b0, 8'd0};
                           fin = 1'b1;
                           state_in = ST_HALT; busy_byte_in = 1'b0;
                        end else begin
                           dist_in = acc_n; state_in = ST_COPY;
                           phase_in = PH_LEN;
                           fin = 1'b0;   // the copy decides the last result
                        end
                     end
                     PH_CNT: begin
                        if (acc_n == '0) begin
                           new_res = 1'b1; new_rsp = '{1'b0, 1'b1, 1'b0, 8'd0};
                           fin = 1'b1;
                           state_in = ST_HALT; busy_byte_in = 1'b0;
                        end else begin
                           lits_in = acc_n[7:0]; phase_in = PH_LIT;
                        end
                     end
                     default: begin
                        wr_en = 1'b1; wr_data = acc_n[7:0];
                        wp_in = (wp_ff == AW'(HIST_DEPTH-1)) ? '0 : wp_ff + 1'b1;
                        if (nw_ff < DepthC) nw_in = nw_ff + 1'b1;
                        new_res = 1'b1; new_rsp = '{1'b0, 1'b0, 1'b0, acc_n[7:0]};
                        lits_in = lits_ff - 8'd1;
                        phase_in = (lits_ff == 8'd1) ? PH_LEN : PH_LIT;
                     end
                  endcase
                  if (phase_ff == PH_LEN) mlen_in = 6'(acc_n);
               end
            end
         end
         ST_COPY: begin
            // read, then write and emit, for each copied byte
            if (!rd_pend_ff) begin
               rd_pend_in = 1'b1;
            end else if (hold_free) begin
               wr_en = 1'b1; wr_data = rd_data;
               wp_in = (wp_ff == AW'(HIST_DEPTH-1)) ? '0 : wp_ff + 1'b1;
               if (nw_ff < DepthC) nw_in = nw_ff + 1'b1;
               new_res = 1'b1; new_rsp = '{1'b0, 1'b0, 1'b0, rd_data};
               fin = (mlen_ff == 6'd0) && !busy_byte_ff;
               mlen_in = mlen_ff - 6'd1;
               if (mlen_ff == 6'd0) state_in = ST_BITS;
               else rd_pend_in = 1'b0; // re-read: source may be the byte just written
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_HALT;
         end
      endcase

      // hold -> output when its flag is settled or a newer result displaces it
      if (hv_ff && out_free && (hfin_ff || new_res)) begin
         ov_in = 1'b1; od_in = hd_ff; hv_in = 1'b0; hfin_in = 1'b0;
      end
      if (new_res) begin
         hv_in = 1'b1; hd_in = new_rsp; hd_in.last_of_run = fin; hfin_in = fin;
      end else if (fin && hv_in) begin
         hd_in.last_of_run = 1'b1; hfin_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BITS; phase_ff <= PH_LEN; acc_ff <= '0; seen_ff <= '0;
         mlen_ff <= '0; lits_ff <= '0; wp_ff <= '0; nw_ff <= '0;
         bit_ff <= 3'd7; rd_pend_ff <= 1'b0; busy_byte_ff <= 1'b0;
         hv_ff <= 1'b0; hfin_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; acc_ff <= acc_in; seen_ff <= seen_in;
         mlen_ff <= mlen_in; lits_ff <= lits_in; wp_ff <= wp_in; nw_ff <= nw_in;
         bit_ff <= bit_in; rd_pend_ff <= rd_pend_in;
         busy_byte_ff <= busy_byte_in;
         hv_ff <= hv_in; hfin_ff <= hfin_in; ov_ff <= ov_in;
      end
      dist_ff <= dist_in; byte_ff <= byte_in; hd_ff <= hd_in; od_ff <= od_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff.out_byte;
   assign rsp_tuser  = {od_ff.bad_offset, od_ff.stream_end};
   assign rsp_tlast  = od_ff.last_of_run;
endmodule

@@ tb/sv/lz77_bit_packed_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// lz77_bit_packed_decoder_tb: self-checking bench for the bit-packed LZ77 decoder
// Builds token streams with a bit-level generator, so that copies only point
// into written history. The field widths change between phases, including
// to out-of-range values. A bit-exact decoder model predicts every output
// transaction. The stream ends with either an end token or a bad offset.
// ----------------------------------------------------------------------------
module lz77_bit_packed_decoder_tb;
   import lzbd_pkg::*;

   localparam int HistDepth = 4096;
   localparam int NumPhases = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = REG_OFFSET_BITS;
   logic [3:0] csr_wdata = 4'd0;

   lz77_bit_packed_decoder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // compressed bytes waiting for the driver, decoded bytes waiting for the DUT
   logic [7:0] pending_bytes[$];
   rsp_type    decoded_q[$];
   int         errors = 0;

   // ------------------------------------------------------------------------
   // Decoder model: widths as last written, parser state, history
   // ------------------------------------------------------------------------
   logic [3:0]  m_off_w = 4'd12, m_len_w = 4'd4, m_cnt_w = 4'd5;
   phase_type   m_phase = PH_LEN;
   logic [11:0] m_acc = '0;
   logic [3:0]  m_seen = '0;
   logic [5:0]  m_len = '0;
   logic [7:0]  m_lits = '0;
   logic [7:0]  m_hist [HistDepth];
   logic [11:0] m_wptr = '0;
   int          m_written = 0;
   bit          m_halted = 0;

   function automatic int width_of(phase_type ph, logic [3:0] ow, logic [3:0] lw,
                                   logic [3:0] cw);
      int w;
      int hi;
      case (ph)
         PH_LEN: begin w = lw; hi = LenMax; end
         PH_OFF: begin w = ow; hi = OffMax; end
         PH_CNT: begin w = cw; hi = CntMax; end
         default: begin w = 8; hi = 8; end
      endcase
      if (w == 0) w = 1;
      if (w > hi) w = hi;
      return w;
   endfunction

   function automatic void record_byte(logic [7:0] b, bit end_flag, bit bad_flag);
      rsp_type r;
      r.out_byte = b;
      r.last_of_run = 1'b0;
      r.stream_end = end_flag;
      r.bad_offset = bad_flag;
      decoded_q.insert(decoded_q.size(), r);
   endfunction

   function automatic void hist_put(logic [7:0] b);
      m_hist[m_wptr] = b;
      m_wptr = m_wptr + 12'd1;
      if (m_written < HistDepth) m_written++;
   endfunction

   // one compressed byte in, MSB first; appends the decoded bytes it yields
   function automatic void decode_byte(logic [7:0] din);
      int  before_n;
      int  w;
      int  v;
      bit  b;
      logic [11:0] src;
      if (m_halted) return;
      before_n = decoded_q.size();
      for (int i = 7; i >= 0 && !m_halted; i--) begin
         b = din[i];
         w = width_of(m_phase, m_off_w, m_len_w, m_cnt_w);
         m_acc = {m_acc[10:0], b};
         m_seen = m_seen + 4'd1;
         if (m_seen >= w) begin
            v = m_acc;
            m_acc = '0;
            m_seen = '0;
            case (m_phase)
               PH_LEN: begin
                  if (v != 0) begin
                     m_len = v[5:0];
                     m_phase = PH_OFF;
                  end else m_phase = PH_CNT;
               end
               PH_OFF: begin
                  if (v == 0 || v > m_written) begin
                     record_byte(8'd0, 1'b0, 1'b1);
                     m_halted = 1;
                  end else begin
                     // byte-by-byte so overlapping copies repeat bytes
                     for (int k = 0; k <= m_len; k++) begin
                        src = m_wptr - 12'(v);
                        record_byte(m_hist[src], 1'b0, 1'b0);
                        hist_put(m_hist[src]);
                     end
                     m_phase = PH_LEN;
                  end
               end
               PH_CNT: begin
                  if (v == 0) begin
                     record_byte(8'd0, 1'b1, 1'b0);
                     m_halted = 1;
                  end else begin
                     m_lits = v[7:0];
                     m_phase = PH_LIT;
                  end
               end
               default: begin
                  hist_put(v[7:0]);
                  record_byte(v[7:0], 1'b0, 1'b0);
                  m_lits = m_lits - 8'd1;
                  m_phase = (m_lits == 0) ? PH_LEN : PH_LIT;
               end
            endcase
         end
      end
      if (decoded_q.size() > before_n)
         decoded_q[decoded_q.size() - 1].last_of_run = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stream generator: tracks the parser position so each field it starts
   // decodes to a legal value under the widths in force; once told to finish,
   // it steers the stream to an end token or a bad offset
   logic [3:0]  g_off_w = 4'd12, g_len_w = 4'd4, g_cnt_w = 4'd5;
   phase_type   g_phase = PH_LEN;
   int          g_acc = 0, g_seen = 0, g_len = 0, g_lits = 0, g_written = 0;
   int          g_target = 0;
   bit          g_finish = 0;    // terminate the stream
   bit          g_end_tok = 1;   // end token, else a bad offset
   bit          g_done = 0;

   function automatic int pick_target(int w);
      int mx;
      int lim;
      mx = (1 << w) - 1;
      case (g_phase)
         PH_LEN: begin
            if (g_written == 0 || (g_finish && g_end_tok)) return 0;
            if (g_finish) return $urandom_range(1, mx);
            if ($urandom_range(0, 3) == 0) return 0;
            return ($urandom_range(0, 5) == 0) ? mx : $urandom_range(1, mx);
         end
         PH_OFF: begin
            if (g_finish)
               return (g_written + 1 <= mx && $urandom_range(0, 1)) ? g_written + 1 : 0;
            lim = (g_written < mx) ? g_written : mx;
            if ($urandom_range(0, 1)) return $urandom_range(1, (lim < 4) ? lim : 4);
            return ($urandom_range(0, 4) == 0) ? lim : $urandom_range(1, lim);
         end
         PH_CNT: begin
            if (g_finish) return 0;
            if (mx <= 31 && $urandom_range(0, 5) == 0) return mx;
            return $urandom_range(1, (mx < 4) ? mx : 4);
         end
         default: begin
            case ($urandom_range(0, 7))
               0: return 0;
               1: return 255;
               default: return $urandom_range(0, 255);
            endcase
         end
      endcase
   endfunction

   function automatic bit next_stream_bit();
      int w;
      int k;
      int v;
      bit b;
      w = width_of(g_phase, g_off_w, g_len_w, g_cnt_w);
      if (g_seen == 0) g_target = pick_target(w);
      k = w - 1 - g_seen;
      b = (k >= 0) ? g_target[k] : 1'b0;
      // a count must not collapse into the end token by accident
      if (g_phase == PH_CNT && !g_finish && k <= 0 && g_acc == 0) b = 1'b1;
      g_acc = ((g_acc << 1) | b) & 12'hfff;
      g_seen++;
      if (g_seen >= w) begin
         v = g_acc;
         g_acc = 0;
         g_seen = 0;
         case (g_phase)
            PH_LEN: begin
               if (v != 0) begin
                  g_len = v;
                  g_phase = PH_OFF;
               end else g_phase = PH_CNT;
            end
            PH_OFF: begin
               if (v == 0 || v > g_written) g_done = 1;
               else begin
                  g_written += g_len + 1;
                  if (g_written > HistDepth) g_written = HistDepth;
                  g_phase = PH_LEN;
               end
            end
            PH_CNT: begin
               if (v == 0) g_done = 1;
               else begin
                  g_lits = v;
                  g_phase = PH_LIT;
               end
            end
            default: begin
               if (g_written < HistDepth) g_written++;
               g_lits--;
               g_phase = (g_lits == 0) ? PH_LEN : PH_LIT;
            end
         endcase
      end
      return b;
   endfunction

   function automatic logic [7:0] next_stream_byte();
      logic [7:0] r;
      for (int i = 7; i >= 0; i--)
         r[i] = g_done ? 1'($urandom_range(0, 1)) : next_stream_bit();
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: bursts of random length, random gaps between them
   // ------------------------------------------------------------------------
   int burst_left = 0, gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered transaction
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= pending_bytes.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         end else burst_left <= burst_left - 1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern drawn at random from four modes; one long hold-off
   // fills the pipe and must back-pressure the input
   // ------------------------------------------------------------------------
   int rx_cycle = 0, rx_mode = 0, hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
         if (rx_cycle == 1500) hold_left <= 400;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Prediction on each accepted input transaction, check on each output one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               REG_OFFSET_BITS: m_off_w = csr_wdata;
               REG_LENGTH_BITS: m_len_w = {1'b0, csr_wdata[2:0]};
               REG_COUNT_BITS:  m_cnt_w = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte = rsp_tdata;
            got.last_of_run = rsp_tlast;
            got.stream_end = rsp_tuser[0];
            got.bad_offset = rsp_tuser[1];
            if (decoded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected output, expected none, actual %h", $time, got);
            end else begin
               want = decoded_q.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  errors++;
                  $display("%0t: out_byte expected %h actual %h", $time,
                           want.out_byte, got.out_byte);
               end
               if (got.last_of_run !== want.last_of_run) begin
                  errors++;
                  $display("%0t: last_of_run expected %b actual %b", $time,
                           want.last_of_run, got.last_of_run);
               end
               if (got.stream_end !== want.stream_end) begin
                  errors++;
                  $display("%0t: stream_end expected %b actual %b", $time,
                           want.stream_end, got.stream_end);
               end
               if (got.bad_offset !== want.bad_offset) begin
                  errors++;
                  $display("%0t: bad_offset expected %b actual %b", $time,
                           want.bad_offset, got.bad_offset);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   task automatic wait_idle();
      while (pending_bytes.size() > 0 || req_tvalid || decoded_q.size() > 0)
         @(posedge clock);
      // a byte may still be in the bit parser without any output yet
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [3:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_OFFSET_BITS: g_off_w = val;
         REG_LENGTH_BITS: g_len_w = {1'b0, val[2:0]};
         default:         g_cnt_w = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // widths per phase {offset, length, count}: defaults, minimums, maximums,
   // zeros (read as 1), above-range values (read as the maximum), mixed, maximums
   logic [3:0] cfg_off [NumPhases] = '{4'd12, 4'd1, 4'd12, 4'd0, 4'd15, 4'd5, 4'd9, 4'd12};
   logic [3:0] cfg_len [NumPhases] = '{4'd4,  4'd1, 4'd5,  4'd0, 4'd7,  4'd3, 4'd2, 4'd5};
   logic [3:0] cfg_cnt [NumPhases] = '{4'd5,  4'd1, 4'd8,  4'd0, 4'd15, 4'd4, 4'd6, 4'd8};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NumPhases; p++) begin
         if (p > 0) wait_idle();
         write_reg(REG_OFFSET_BITS, cfg_off[p]);
         write_reg(REG_LENGTH_BITS, cfg_len[p]);
         write_reg(REG_COUNT_BITS, cfg_cnt[p]);
         for (int i = 0; i < 22; i++)
            pending_bytes.insert(pending_bytes.size(), next_stream_byte());
      end
      // terminate: end token or bad offset, then bytes the halted block drops
      g_end_tok = $urandom_range(0, 1);
      g_finish = 1;
      while (!g_done) pending_bytes.insert(pending_bytes.size(), next_stream_byte());
      repeat (4) pending_bytes.insert(pending_bytes.size(), next_stream_byte());
      wait_idle();
      repeat (60) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
